FILE: design/cbp_pkg.sv
package cbp_pkg;

   localparam logic [1:0] CMD_START = 2'd0;
   localparam logic [1:0] CMD_RECV  = 2'd1;
   localparam logic [1:0] CMD_FAIL  = 2'd2;
   localparam logic [1:0] CMD_NONE  = 2'd3;

   localparam logic [1:0] ACT_SEND = 2'd0;
   localparam logic [1:0] ACT_COPY = 2'd1;
   localparam logic [1:0] ACT_DONE = 2'd2;
   localparam logic [1:0] ACT_ERR  = 2'd3;

   localparam logic [1:0] CSR_CID_ENABLE     = 2'd0;
   localparam logic [1:0] CSR_NAD_ENABLE     = 2'd1;
   localparam logic [1:0] CSR_MAX_INF_LENGTH = 2'd2;

   localparam logic [7:0] PCB_I_BASE    = 8'h02;
   localparam logic [7:0] PCB_R_BASE    = 8'hA2;
   localparam logic [7:0] PCB_S_WTX     = 8'hF2;
   localparam logic [7:0] PCB_S_MASK    = 8'hF0;
   localparam logic [7:0] PCB_I_MASK    = 8'hC0;
   localparam logic [7:0] PCB_R_MASK    = 8'hE0;
   localparam logic [7:0] PCB_R_MATCH   = 8'hA0;
   localparam logic [7:0] PCB_BIT_BN    = 8'h01;
   localparam logic [7:0] PCB_BIT_NAD   = 8'h04;
   localparam logic [7:0] PCB_BIT_CID   = 8'h08;
   localparam logic [7:0] PCB_BIT_CHAIN = 8'h10;
   localparam logic [7:0] TX_CID_VALUE  = 8'h01;

   localparam logic [7:0] MAX_INF_RESET = 8'd254;

   typedef enum logic [2:0] {
      KIND_START = 3'd0,
      KIND_FAIL  = 3'd1,
      KIND_SWTX  = 3'd2,
      KIND_IBLK  = 3'd3,
      KIND_RBLK  = 3'd4,
      KIND_OTHER = 3'd5
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [15:0] apdu_length;
      logic        blk_bit;
      logic        empty;
      logic        chain_bit;
      logic        swtx_cid;
      logic [7:0]  cid_byte;
      logic [5:0]  wtxm;
      logic [1:0]  skip;
      logic [7:0]  copy_length;
   } entry_type;

   typedef struct packed {
      logic [1:0]  action;
      logic [7:0]  tx_pcb;
      logic [7:0]  tx_cid_byte;
      logic [15:0] tx_inf_offset;
      logic [7:0]  tx_inf_length;
      logic [5:0]  tx_wtxm;
      logic [1:0]  rx_skip;
      logic [15:0] rx_offset;
      logic [7:0]  rx_copy_length;
      logic        last;
   } rsp_type;

   function automatic rsp_type rsp_blank();
      rsp_type r;
      r = '0;
      r.action = ACT_SEND;
      r.rx_skip = 2'd1;
      r.last = 1'b1;
      return r;
   endfunction

endpackage

FILE: design/cbp_front.sv
module cbp_front
   import cbp_pkg::*;
(
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,
   input  logic [55:0] req_tdata,
   input  logic        queue_full,
   output logic        push,
   output entry_type   push_entry
);

   logic [15:0] apdu_length;
   logic [7:0]  pcb;
   logic [7:0]  byte1;
   logic [7:0]  byte2;
   logic [8:0]  rx_length;
   logic [1:0]  skip;
   logic [8:0]  remain;

   assign apdu_length = req_tdata[15:0];
   assign pcb         = req_tdata[23:16];
   assign byte1       = req_tdata[31:24];
   assign byte2       = req_tdata[39:32];
   assign rx_length   = req_tdata[48:40];

   assign req_tready = !queue_full;
   assign push       = req_tvalid && !queue_full && (req_tuser != CMD_NONE);

   assign skip   = 2'd1 + {1'b0, pcb[3]} + {1'b0, pcb[2]};
   assign remain = (rx_length > {7'd0, skip}) ? rx_length - {7'd0, skip} : 9'd0;

   always_comb begin
      push_entry             = '0;
      push_entry.apdu_length = apdu_length;
      push_entry.blk_bit     = pcb[0];
      push_entry.empty       = (rx_length == 9'd0);
      push_entry.chain_bit   = |(pcb & PCB_BIT_CHAIN);
      push_entry.swtx_cid    = |(pcb & PCB_BIT_CID);
      push_entry.cid_byte    = byte1;
      push_entry.wtxm        = push_entry.swtx_cid ? byte2[5:0] : byte1[5:0];
      push_entry.skip        = skip;
      push_entry.copy_length = remain[8] ? 8'hFF : remain[7:0];
      unique case (req_tuser)
         CMD_START: push_entry.kind = KIND_START;
         CMD_FAIL:  push_entry.kind = KIND_FAIL;
         default: begin
            if ((pcb & PCB_S_MASK) == PCB_S_MASK) begin
               push_entry.kind = KIND_SWTX;
            end else if ((pcb & PCB_I_MASK) == 8'h00) begin
               push_entry.kind = KIND_IBLK;
            end else if ((pcb & PCB_R_MASK) == PCB_R_MATCH) begin
               push_entry.kind = KIND_RBLK;
            end else begin
               push_entry.kind = KIND_OTHER;
            end
         end
      endcase
   end

endmodule

FILE: design/cbp_queue.sv
module cbp_queue
   import cbp_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   output logic      full,
   input  logic      pop,
   output logic      valid,
   output entry_type head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type        entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full  = (count_ff == CNT_W'(DEPTH));
   assign valid = (count_ff != '0);
   assign head  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count beyond depth");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full && !pop |=> wr_ptr_ff == $past(wr_ptr_ff))
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> valid)
      else $error("queue read while empty");

endmodule

FILE: design/cbp_back.sv
module cbp_back
   import cbp_pkg::*;
#(
   parameter int RETRY_LIMIT = 3
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_we,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_wdata,
   input  logic       entry_valid,
   input  entry_type  entry,
   output logic       pop,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output rsp_type    rsp
);

   localparam logic [2:0] RETRY_MAX = 3'(RETRY_LIMIT);

   logic        cid_en_ff;
   logic        nad_en_ff;
   logic [7:0]  max_inf_ff;

   logic        bn_ff, bn_in;
   logic [15:0] send_off_ff, send_off_in;
   logic [15:0] recv_off_ff, recv_off_in;
   logic [15:0] total_ff, total_in;
   logic        chain_ff, chain_in;
   logic [2:0]  retry_ff, retry_in;
   logic        busy_ff, busy_in;

   rsp_type     out_ff, out_in;
   logic        out_valid_ff, out_valid_in;
   rsp_type     pend_ff, pend_in;
   logic        pend_valid_ff, pend_valid_in;

   logic [7:0]  mx;
   logic [15:0] rem_now;
   logic [15:0] off_adv;
   logic [15:0] rem_adv;
   logic        chain_now;
   logic        chain_adv;
   logic        chain_start;
   logic [2:0]  retry_next;
   logic [15:0] recv_sum;
   logic        out_free;
   rsp_type     r0, r1;
   logic        two;

   function automatic rsp_type iblock_rsp(input logic bn, input logic nad, input logic cid,
                                          input logic chain, input logic [7:0] len,
                                          input logic [15:0] off);
      rsp_type r;
      r = rsp_blank();
      r.action = ACT_SEND;
      r.tx_pcb = PCB_I_BASE | (bn ? PCB_BIT_BN : 8'h00) | (nad ? PCB_BIT_NAD : 8'h00)
               | (cid ? PCB_BIT_CID : 8'h00) | (chain ? PCB_BIT_CHAIN : 8'h00);
      r.tx_cid_byte   = cid ? TX_CID_VALUE : 8'h00;
      r.tx_inf_offset = off;
      r.tx_inf_length = len;
      return r;
   endfunction

   function automatic rsp_type rblock_rsp(input logic bn, input logic nak, input logic cid);
      rsp_type r;
      r = rsp_blank();
      r.action = ACT_SEND;
      r.tx_pcb = PCB_R_BASE | (bn ? PCB_BIT_BN : 8'h00) | (nak ? PCB_BIT_CHAIN : 8'h00)
               | (cid ? PCB_BIT_CID : 8'h00);
      r.tx_cid_byte = cid ? TX_CID_VALUE : 8'h00;
      return r;
   endfunction

   assign mx          = (max_inf_ff == 8'd0) ? 8'd1 : max_inf_ff;
   assign rem_now     = (send_off_ff > total_ff) ? 16'd0 : total_ff - send_off_ff;
   assign off_adv     = send_off_ff + {8'd0, mx};
   assign rem_adv     = (off_adv > total_ff) ? 16'd0 : total_ff - off_adv;
   assign chain_now   = rem_now > {8'd0, mx};
   assign chain_adv   = rem_adv > {8'd0, mx};
   assign chain_start = entry.apdu_length > {8'd0, mx};
   assign retry_next  = retry_ff + 3'd1;
   assign recv_sum    = recv_off_ff + {8'd0, entry.copy_length};
   assign out_free    = !out_valid_ff || rsp_tready;
   assign pop         = out_free && !pend_valid_ff && entry_valid;

   assign rsp_tvalid = out_valid_ff;
   assign rsp        = out_ff;

   always_comb begin
      bn_in       = bn_ff;
      send_off_in = send_off_ff;
      recv_off_in = recv_off_ff;
      total_in    = total_ff;
      chain_in    = chain_ff;
      retry_in    = retry_ff;
      busy_in     = busy_ff;
      r0          = rsp_blank();
      r1          = rsp_blank();
      two         = 1'b0;
      if (pop) begin
         if (entry.kind == KIND_START) begin
            total_in    = entry.apdu_length;
            send_off_in = '0;
            recv_off_in = '0;
            retry_in    = '0;
            busy_in     = 1'b1;
            chain_in    = chain_start;
            r0 = iblock_rsp(bn_ff, nad_en_ff, cid_en_ff, chain_start,
                            chain_start ? mx : entry.apdu_length[7:0], 16'd0);
         end else if (!busy_ff) begin
            r0.action = ACT_ERR;
         end else begin
            retry_in = '0;
            unique case (entry.kind)
               KIND_FAIL: begin
                  if (retry_next >= RETRY_MAX) begin
                     busy_in   = 1'b0;
                     r0.action = ACT_ERR;
                  end else begin
                     retry_in = retry_next;
                     r0 = rblock_rsp(bn_ff, 1'b1, cid_en_ff);
                  end
               end
               KIND_SWTX: begin
                  r0.action  = ACT_SEND;
                  r0.tx_pcb  = PCB_S_WTX;
                  r0.tx_wtxm = entry.wtxm;
                  if (entry.swtx_cid && cid_en_ff) begin
                     r0.tx_pcb      = PCB_S_WTX | PCB_BIT_CID;
                     r0.tx_cid_byte = entry.cid_byte;
                  end
               end
               KIND_IBLK: begin
                  if (entry.blk_bit != bn_ff || entry.empty) begin
                     busy_in   = 1'b0;
                     r0.action = ACT_ERR;
                  end else begin
                     two               = 1'b1;
                     bn_in             = !bn_ff;
                     recv_off_in       = recv_sum;
                     r0.action         = ACT_COPY;
                     r0.rx_skip        = entry.skip;
                     r0.rx_offset      = recv_off_ff;
                     r0.rx_copy_length = entry.copy_length;
                     r0.last           = 1'b0;
                     if (entry.chain_bit) begin
                        r1 = rblock_rsp(!bn_ff, 1'b0, cid_en_ff);
                     end else begin
                        busy_in      = 1'b0;
                        r1.action    = ACT_DONE;
                        r1.rx_offset = recv_sum;
                     end
                  end
               end
               KIND_RBLK: begin
                  if (entry.blk_bit == bn_ff) begin
                     bn_in = !bn_ff;
                     if (!chain_ff) begin
                        busy_in   = 1'b0;
                        r0.action = ACT_ERR;
                     end else begin
                        send_off_in = off_adv;
                        chain_in    = chain_adv;
                        r0 = iblock_rsp(!bn_ff, nad_en_ff, cid_en_ff, chain_adv,
                                        chain_adv ? mx : rem_adv[7:0], off_adv);
                     end
                  end else begin
                     chain_in = chain_now;
                     r0 = iblock_rsp(bn_ff, nad_en_ff, cid_en_ff, chain_now,
                                     chain_now ? mx : rem_now[7:0], send_off_ff);
                  end
               end
               default: begin
                  busy_in      = 1'b0;
                  r0.action    = ACT_DONE;
                  r0.rx_offset = recv_off_ff;
               end
            endcase
         end
      end
   end

   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      if (out_free) begin
         if (pend_valid_ff) begin
            out_in        = pend_ff;
            out_valid_in  = 1'b1;
            pend_valid_in = 1'b0;
         end else if (entry_valid) begin
            out_in        = r0;
            out_valid_in  = 1'b1;
            pend_in       = r1;
            pend_valid_in = two;
         end else begin
            out_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cid_en_ff     <= 1'b1;
         nad_en_ff     <= 1'b0;
         max_inf_ff    <= MAX_INF_RESET;
         bn_ff         <= 1'b0;
         send_off_ff   <= '0;
         recv_off_ff   <= '0;
         total_ff      <= '0;
         chain_ff      <= 1'b0;
         retry_ff      <= '0;
         busy_ff       <= 1'b0;
         out_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_CID_ENABLE:     cid_en_ff  <= csr_wdata[0];
               CSR_NAD_ENABLE:     nad_en_ff  <= csr_wdata[0];
               CSR_MAX_INF_LENGTH: max_inf_ff <= csr_wdata;
               default: ;
            endcase
         end
         bn_ff         <= bn_in;
         send_off_ff   <= send_off_in;
         recv_off_ff   <= recv_off_in;
         total_ff      <= total_in;
         chain_ff      <= chain_in;
         retry_ff      <= retry_in;
         busy_ff       <= busy_in;
         out_valid_ff  <= out_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      pend_ff <= pend_in;
   end

   a_pend_behind_out: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> out_valid_ff)
      else $error("second result held without a first");

   a_retry_bound: assert property (@(posedge clock) disable iff (reset)
      retry_ff < RETRY_MAX)
      else $error("retry count reached limit");

   a_busy_end: assert property (@(posedge clock) disable iff (reset)
      $fell(busy_ff) |-> (out_valid_ff && (out_ff.action == ACT_ERR
         || out_ff.action == ACT_DONE)) || (pend_valid_ff && pend_ff.action == ACT_DONE))
      else $error("exchange ended without completion or error");

   a_pend_last: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> pend_ff.last && !out_ff.last)
      else $error("result pair marked wrong");

endmodule

FILE: design/contactless_block_protocol_step.sv
// Reader-side step of the contactless half-duplex block protocol. Each request on req_ is a
// start command, a received block header, an exchange failure or none; each but none yields
// one result on rsp_ (two for an accepted I-block: a copy window, then an R(ACK) or
// completion), the final one flagged by rsp_tlast. A front stage classifies each request
// into a queue of QUEUE_DEPTH entries; the back stage takes one entry per cycle while the
// output register is free and no second result is pending, updates the protocol state and
// fills the output register. Sustained rate is one result per cycle while rsp_tready holds,
// set by the single result register feeding rsp_. Registers on csr_: 0 cid_enable,
// 1 nad_enable, 2 max_inf_length; write them only while no result is outstanding.
module contactless_block_protocol_step
   import cbp_pkg::*;
#(
   parameter int RETRY_LIMIT = 3,
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // cmd
   input  logic [55:0] req_tdata,   // apdu_length, rx_pcb, rx_byte1, rx_byte2, rx_length
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [1:0]  rsp_tuser,   // action
   output logic [71:0] rsp_tdata,   // tx_pcb, tx_cid_byte, tx_inf_offset, tx_inf_length,
                                    // tx_wtxm, rx_skip, rx_offset, rx_copy_length
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   logic      push;
   entry_type push_entry;
   logic      queue_full;
   logic      pop;
   logic      entry_valid;
   entry_type entry;
   rsp_type   rsp;

   cbp_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .queue_full (queue_full),
      .push       (push),
      .push_entry (push_entry)
   );

   cbp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .valid      (entry_valid),
      .head       (entry)
   );

   cbp_back #(
      .RETRY_LIMIT (RETRY_LIMIT)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .entry_valid (entry_valid),
      .entry       (entry),
      .pop         (pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp         (rsp)
   );

   assign rsp_tuser = rsp.action;
   assign rsp_tlast = rsp.last;
   assign rsp_tdata = {rsp.rx_copy_length, rsp.rx_offset, rsp.rx_skip, rsp.tx_wtxm,
                       rsp.tx_inf_length, rsp.tx_inf_offset, rsp.tx_cid_byte, rsp.tx_pcb};

endmodule

FILE: verif/contactless_block_protocol_step_tb.sv
`timescale 1ns / 100ps

module contactless_block_protocol_step_tb;
   import cbp_pkg::*;

   localparam int PHASES        = 8;
   localparam int PHASE_ITEMS   = 219;
   localparam int SETTLE_CYCLES = 4;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int MAX_STEPS     = 40;

   class frame_scoreboard;
      localparam int RETRY_LIMIT = 3;

      bit          cid_en;
      bit          nad_en;
      logic [7:0]  max_inf;
      bit          blk_num;
      logic [15:0] send_off;
      logic [15:0] recv_off;
      logic [15:0] apdu_total;
      bit          chaining;
      logic [2:0]  retries;
      bit          busy;
      rsp_type     frames_due[$];
      int          mismatches;
      int          n_results;
      int          action_count[4];

      function new();
         cid_en = 1'b1;
         nad_en = 1'b0;
         max_inf = 8'd254;
         blk_num = 1'b0;
         send_off = '0;
         recv_off = '0;
         apdu_total = '0;
         chaining = 1'b0;
         retries = '0;
         busy = 1'b0;
      endfunction

      function void write_reg(logic [1:0] idx, logic [7:0] val);
         case (idx)
            CSR_CID_ENABLE:     cid_en = val[0];
            CSR_NAD_ENABLE:     nad_en = val[0];
            CSR_MAX_INF_LENGTH: max_inf = val;
            default: ;
         endcase
      endfunction

      function logic [7:0] step_size();
         return (max_inf == 8'd0) ? 8'd1 : max_inf;
      endfunction

      function rsp_type blank_result();
         rsp_type r;
         r = '0;
         r.action = ACT_SEND;
         r.rx_skip = 2'd1;
         r.last = 1'b1;
         return r;
      endfunction

      function rsp_type iblock_result();
         rsp_type     r;
         logic [15:0] left;
         logic [15:0] mx;
         r = blank_result();
         left = (send_off > apdu_total) ? 16'd0 : apdu_total - send_off;
         mx = {8'd0, step_size()};
         chaining = (left > mx);
         r.tx_pcb = PCB_I_BASE | (blk_num ? PCB_BIT_BN : 8'h00) | (nad_en ? PCB_BIT_NAD : 8'h00)
                  | (cid_en ? PCB_BIT_CID : 8'h00) | (chaining ? PCB_BIT_CHAIN : 8'h00);
         r.tx_cid_byte = cid_en ? TX_CID_VALUE : 8'h00;
         r.tx_inf_offset = send_off;
         r.tx_inf_length = chaining ? mx[7:0] : left[7:0];
         return r;
      endfunction

      function rsp_type rblock_result(bit nak);
         rsp_type r;
         r = blank_result();
         r.tx_pcb = PCB_R_BASE | (blk_num ? PCB_BIT_BN : 8'h00) | (nak ? PCB_BIT_CHAIN : 8'h00)
                  | (cid_en ? PCB_BIT_CID : 8'h00);
         r.tx_cid_byte = cid_en ? TX_CID_VALUE : 8'h00;
         return r;
      endfunction

      function void end_with_error();
         rsp_type r;
         r = blank_result();
         r.action = ACT_ERR;
         frames_due.push_back(r);
         busy = 1'b0;
      endfunction

      function void note_request(logic [1:0] cmd, logic [15:0] alen, logic [7:0] pcb,
                                 logic [7:0] b1, logic [7:0] b2, logic [8:0] rlen);
         rsp_type r;
         int      skip;
         int      cnt;
         if (cmd == CMD_NONE) return;
         if (cmd == CMD_START) begin
            apdu_total = alen;
            send_off = '0;
            recv_off = '0;
            retries = '0;
            busy = 1'b1;
            frames_due.push_back(iblock_result());
            return;
         end
         if (!busy) begin
            end_with_error();
            return;
         end
         if (cmd == CMD_FAIL) begin
            retries = retries + 3'd1;
            if (retries >= RETRY_LIMIT) begin
               retries = '0;
               end_with_error();
            end else begin
               frames_due.push_back(rblock_result(1'b1));
            end
            return;
         end
         retries = '0;
         if ((pcb & PCB_S_MASK) == PCB_S_MASK) begin
            r = blank_result();
            r.tx_pcb = PCB_S_WTX;
            if (pcb[3] && cid_en) begin
               r.tx_pcb = PCB_S_WTX | PCB_BIT_CID;
               r.tx_cid_byte = b1;
            end
            r.tx_wtxm = pcb[3] ? b2[5:0] : b1[5:0];
            frames_due.push_back(r);
         end else if ((pcb & PCB_I_MASK) == 8'h00) begin
            if (pcb[0] != blk_num || rlen == 9'd0) begin
               end_with_error();
               return;
            end
            skip = 1 + int'(pcb[3]) + int'(pcb[2]);
            cnt = (int'(rlen) > skip) ? int'(rlen) - skip : 0;
            if (cnt > 255) cnt = 255;
            r = blank_result();
            r.action = ACT_COPY;
            r.rx_skip = 2'(skip);
            r.rx_offset = recv_off;
            r.rx_copy_length = 8'(cnt);
            r.last = 1'b0;
            frames_due.push_back(r);
            recv_off = recv_off + 16'(cnt);
            blk_num = ~blk_num;
            if (pcb[4]) begin
               r = rblock_result(1'b0);
            end else begin
               r = blank_result();
               r.action = ACT_DONE;
               r.rx_offset = recv_off;
               busy = 1'b0;
            end
            frames_due.push_back(r);
         end else if ((pcb & PCB_R_MASK) == PCB_R_MATCH) begin
            if (pcb[0] == blk_num) begin
               blk_num = ~blk_num;
               if (!chaining) begin
                  end_with_error();
                  return;
               end
               send_off = send_off + {8'd0, step_size()};
            end
            frames_due.push_back(iblock_result());
         end else begin
            r = blank_result();
            r.action = ACT_DONE;
            r.rx_offset = recv_off;
            frames_due.push_back(r);
            busy = 1'b0;
         end
      endfunction

      task report(string msg);
         mismatches++;
         if (mismatches <= 40) $display("%0t mismatch: %s", $time, msg);
      endtask

      task compare_field(string name, logic [15:0] got, logic [15:0] want);
         if (got !== want)
            report($sformatf("result %0d %s: got 0x%0h, want 0x%0h", n_results, name, got, want));
      endtask

      task check_result(rsp_type got);
         rsp_type want;
         n_results++;
         if (frames_due.size() == 0) begin
            report($sformatf("result %0d with nothing due, action %0d pcb 0x%0h",
                             n_results, got.action, got.tx_pcb));
            return;
         end
         want = frames_due.pop_front();
         action_count[want.action]++;
         compare_field("action", 16'(got.action), 16'(want.action));
         compare_field("tx_pcb", 16'(got.tx_pcb), 16'(want.tx_pcb));
         compare_field("tx_cid_byte", 16'(got.tx_cid_byte), 16'(want.tx_cid_byte));
         compare_field("tx_inf_offset", got.tx_inf_offset, want.tx_inf_offset);
         compare_field("tx_inf_length", 16'(got.tx_inf_length), 16'(want.tx_inf_length));
         compare_field("tx_wtxm", 16'(got.tx_wtxm), 16'(want.tx_wtxm));
         compare_field("rx_skip", 16'(got.rx_skip), 16'(want.rx_skip));
         compare_field("rx_offset", got.rx_offset, want.rx_offset);
         compare_field("rx_copy_length", 16'(got.rx_copy_length), 16'(want.rx_copy_length));
         compare_field("last", 16'(got.last), 16'(want.last));
      endtask
   endclass

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [1:0]  req_tuser = CMD_NONE;
   logic [55:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [1:0]  rsp_tuser;
   logic [71:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = CSR_CID_ENABLE;
   logic [7:0]  csr_wdata = '0;

   frame_scoreboard frames = new();
   rsp_type         seen;
   bit              idle_on = 1'b1;
   bit              quiet = 1'b0;
   int              rsp_hold = 0;
   int              n_sent = 0;
   int              settings_count = 0;
   int              cycle_count = 0;

   contactless_block_protocol_step u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results due", cycle_count,
                  frames.frames_due.size());
         $display("end of test: mismatches");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen.action = rsp_tuser;
         seen.tx_pcb = rsp_tdata[7:0];
         seen.tx_cid_byte = rsp_tdata[15:8];
         seen.tx_inf_offset = rsp_tdata[31:16];
         seen.tx_inf_length = rsp_tdata[39:32];
         seen.tx_wtxm = rsp_tdata[45:40];
         seen.rx_skip = rsp_tdata[47:46];
         seen.rx_offset = rsp_tdata[63:48];
         seen.rx_copy_length = rsp_tdata[71:64];
         seen.last = rsp_tlast;
         frames.check_result(seen);
      end
      if (rsp_hold != 0) begin
         rsp_hold <= rsp_hold - 1;
         rsp_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
         rsp_hold <= int'($urandom_range(0, 7));
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   function automatic logic [7:0] rnd8();
      return 8'($urandom);
   endfunction

   function automatic logic [15:0] rnd16();
      return 16'($urandom);
   endfunction

   function automatic logic [8:0] rnd_len(int lo, int hi);
      return 9'($urandom_range(hi, lo));
   endfunction

   task automatic send_request(logic [1:0] cmd, logic [15:0] alen, logic [7:0] pcb,
                               logic [7:0] b1, logic [7:0] b2, logic [8:0] rlen);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= {7'd0, rlen, b2, b1, pcb, alen};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      frames.note_request(cmd, alen, pcb, b1, b2, rlen);
      if (cmd != CMD_NONE) n_sent++;
   endtask

   task automatic send_start(logic [15:0] alen);
      send_request(CMD_START, alen, rnd8(), rnd8(), rnd8(), rnd_len(0, 256));
   endtask

   task automatic send_fail();
      send_request(CMD_FAIL, rnd16(), rnd8(), rnd8(), rnd8(), rnd_len(0, 256));
   endtask

   task automatic send_block(logic [7:0] pcb, logic [7:0] b1, logic [7:0] b2, logic [8:0] rlen);
      send_request(CMD_RECV, rnd16(), pcb, b1, b2, rlen);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (frames.frames_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic configure(bit cid, bit nad, logic [7:0] mx);
      csr_we <= 1'b1;
      csr_index <= CSR_CID_ENABLE;
      csr_wdata <= {7'd0, cid};
      @(posedge clock);
      csr_index <= CSR_NAD_ENABLE;
      csr_wdata <= {7'd0, nad};
      @(posedge clock);
      csr_index <= CSR_MAX_INF_LENGTH;
      csr_wdata <= mx;
      @(posedge clock);
      csr_we <= 1'b0;
      frames.write_reg(CSR_CID_ENABLE, {7'd0, cid});
      frames.write_reg(CSR_NAD_ENABLE, {7'd0, nad});
      frames.write_reg(CSR_MAX_INF_LENGTH, mx);
      settings_count++;
   endtask

   function automatic logic [7:0] cur_bn();
      return frames.blk_num ? PCB_BIT_BN : 8'h00;
   endfunction

   function automatic logic [8:0] card_length();
      return ($urandom_range(0, 7) == 0) ? rnd_len(0, 256) : rnd_len(1, 12);
   endfunction

   initial begin
      int         phase;
      int         phase_end;
      int         pick;
      int         mx;
      int         steps;
      bit         cid_sel;
      bit         nad_sel;
      logic [7:0] mx_sel;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_block(PCB_I_BASE, 8'h00, 8'h00, 9'd5);
      send_fail();
      send_request(CMD_NONE, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 9'd256);
      send_start(16'd0);
      send_block(PCB_I_BASE | PCB_BIT_CID | cur_bn(), 8'h01, 8'h00, 9'd1);
      send_start(16'hFFFF);
      send_block(PCB_R_BASE | cur_bn(), 8'h01, 8'h00, 9'd2);
      send_block(PCB_R_BASE | PCB_BIT_CHAIN | (cur_bn() ^ PCB_BIT_BN), 8'h01, 8'h00, 9'd2);
      send_block(PCB_S_WTX | PCB_BIT_CID, 8'h5A, 8'hFF, 9'd3);
      send_block(PCB_S_WTX, 8'hFF, 8'h00, 9'd2);
      repeat (3) send_fail();
      send_start(16'd300);
      send_block(PCB_R_BASE | cur_bn(), 8'h01, 8'h00, 9'd2);
      send_block(PCB_I_BASE | PCB_BIT_CHAIN | PCB_BIT_CID | PCB_BIT_NAD | cur_bn(),
                 8'h01, 8'h00, 9'd256);
      send_block(PCB_I_BASE | PCB_BIT_CHAIN | cur_bn(), 8'hAA, 8'h55, 9'd256);
      send_block(PCB_I_BASE | (cur_bn() ^ PCB_BIT_BN), 8'h00, 8'h00, 9'd10);
      send_start(16'd10);
      send_block(PCB_R_BASE | cur_bn(), 8'h01, 8'h00, 9'd2);
      send_start(16'd5);
      send_block(PCB_I_BASE | cur_bn(), 8'h00, 8'h00, 9'd0);
      send_start(16'd20);
      send_start(16'd21);
      send_block(8'hC2, 8'h00, 8'h00, 9'd1);

      steps = 0;
      for (phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin cid_sel = 1'b0; nad_sel = 1'b1; mx_sel = 8'd1; end
            1: begin cid_sel = 1'b1; nad_sel = 1'b1; mx_sel = 8'd254; end
            2: begin cid_sel = 1'b0; nad_sel = 1'b0; mx_sel = 8'd2; end
            3: begin cid_sel = 1'b1; nad_sel = 1'b0; mx_sel = 8'd254; end
            default: begin
               cid_sel = 1'($urandom_range(0, 1));
               nad_sel = 1'($urandom_range(0, 1));
               mx_sel = ($urandom_range(0, 3) == 0) ? 8'd254 : 8'($urandom_range(1, 24));
            end
         endcase
         wait_idle();
         configure(cid_sel, nad_sel, mx_sel);
         quiet = (phase == PHASES - 1);
         if (quiet) idle_on = 1'b0;
         phase_end = n_sent + PHASE_ITEMS;
         while (n_sent < phase_end) begin
            if (!frames.busy || steps >= MAX_STEPS) begin
               if (!frames.busy && $urandom_range(0, 9) == 0) begin
                  if ($urandom_range(0, 1)) send_fail();
                  else send_block(rnd8(), rnd8(), rnd8(), rnd_len(0, 256));
               end else begin
                  if (!quiet) idle_on = ($urandom_range(0, 3) != 0);
                  if (!quiet && $urandom_range(0, 19) == 0) wait_idle();
                  mx = int'(frames.step_size());
                  send_start(($urandom_range(0, 15) == 0) ? rnd16()
                                                         : 16'($urandom_range(0, 3 * mx + 2)));
                  steps = 0;
               end
            end else begin
               steps++;
               pick = int'($urandom_range(0, 99));
               if (frames.chaining && pick < 55) begin
                  send_block(PCB_R_MATCH | (rnd8() & 8'h1E) | cur_bn(), rnd8(), rnd8(),
                             rnd_len(1, 3));
               end else if (pick < 55) begin
                  send_block((rnd8() & 8'h3E) | cur_bn(), rnd8(), rnd8(), card_length());
               end else if (pick < 65) begin
                  send_block(PCB_R_MATCH | (rnd8() & 8'h1E) | (cur_bn() ^ PCB_BIT_BN),
                             rnd8(), rnd8(), rnd_len(1, 3));
               end else if (pick < 73) begin
                  send_block(PCB_S_MASK | (rnd8() & 8'h0F), rnd8(), rnd8(), rnd_len(2, 3));
               end else if (pick < 85) begin
                  repeat ($urandom_range(1, 3)) send_fail();
               end else if (pick < 89) begin
                  send_request(CMD_NONE, rnd16(), rnd8(), rnd8(), rnd8(), rnd_len(0, 256));
               end else begin
                  send_block(rnd8(), rnd8(), rnd8(), rnd_len(0, 256));
               end
            end
         end
      end

      req_tvalid <= 1'b0;
      while (frames.frames_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("covered %0d requests, %0d results: %0d frames sent, %0d copies,",
               n_sent, frames.n_results, frames.action_count[ACT_SEND],
               frames.action_count[ACT_COPY]);
      $display("%0d done, %0d errors over %0d register settings, with random stalls",
               frames.action_count[ACT_DONE], frames.action_count[ACT_ERR], settings_count);
      if (frames.mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

FILE: sim.f
design/cbp_pkg.sv
design/cbp_front.sv
design/cbp_queue.sv
design/cbp_back.sv
design/contactless_block_protocol_step.sv
verif/contactless_block_protocol_step_tb.sv
